/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/tphb_pkg.sv */
`default_nettype none
package tphb_pkg;

	// Header layout
	localparam int unsigned HDR_WORDS = 10;
	localparam logic [3:0] FIRST_IDX = 4'd0;
	localparam logic [3:0] LAST_IDX = 4'd9;

	// Fixed header fields
	localparam logic [31:0] IP_WORD0 = 32'h4500_0028;
	localparam logic [15:0] IP_DF = 16'h4000;
	localparam logic [31:0] IP_WORD2 = 32'h4006_0000;
	localparam logic [15:0] TCP_OFF_HI = 16'h5000;
	localparam logic [15:0] TCP_WINDOW = 16'd29200;
	// Pseudo-header protocol plus TCP length
	localparam logic [15:0] PSEUDO_CONST = 16'd26;

	// TCP flag bits
	localparam logic [5:0] FL_NONE = 6'h00;
	localparam logic [5:0] FL_FIN = 6'h01;
	localparam logic [5:0] FL_SYN = 6'h02;
	localparam logic [5:0] FL_PSH = 6'h08;
	localparam logic [5:0] FL_URG = 6'h20;

	// Register address width and register select values (paddr bit 2)
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
	} cfg_t;

	// Lowest set kind bit picks the flag set
	function automatic logic [5:0] kind_flags(input logic [2:0] kind);
		logic [5:0] f;
		begin
			if (kind[0]) f = FL_FIN;
			else if (kind[1]) f = FL_SYN;
			else if (kind[2]) f = FL_FIN | FL_PSH | FL_URG;
			else f = FL_NONE;
			return f;
		end
	endfunction

endpackage
`default_nettype wire

/* src/tphb_regs.sv */
`default_nettype none
`include "assert_macros.svh"
module tphb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tphb_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output tphb_pkg::cfg_t                     cfg
);

	logic wr_en;
	tphb_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				tphb_pkg::REG_SOURCE: cfg_q.source_address <= pwdata;
				tphb_pkg::REG_TARGET: cfg_q.dest_address <= pwdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			tphb_pkg::REG_SOURCE: prdata = cfg_q.source_address;
			tphb_pkg::REG_TARGET: prdata = cfg_q.dest_address;
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

	`ASSERT_NEXT(a_src_write, clk, arst_n, wr_en && (paddr[2] == tphb_pkg::REG_SOURCE), cfg_q.source_address == $past(pwdata))
	`ASSERT_NEXT(a_dst_write, clk, arst_n, wr_en && (paddr[2] == tphb_pkg::REG_TARGET), cfg_q.dest_address == $past(pwdata))
	`ASSERT_NEXT(a_cfg_hold, clk, arst_n, !wr_en, $stable(cfg_q))

endmodule
`default_nettype wire

/* src/tcp_probe_header_builder.sv */
// Builds a 40-byte IPv4+TCP probe header from one probe request and sends it as ten
// 32-bit network-order words (word_index 0..9, last_word on the tenth), one word per
// cycle while out_stall is low; the next header loads only after the last word is taken.
// A request passes two pipeline stages (port/sequence and address partial sums, then
// the full checksum sum) and the checksum fold is done as it loads into the output
// serializer, whose register then presents the first word. Up to two more
// requests are held in the pipeline while a header is still draining. The IP header
// checksum is sent as zero; a TCP checksum that computes to zero is sent as zero.
// source_address and dest_address live at byte addresses 0 and 4 of the APB port
// and must only be changed while no probe is in flight.
`default_nettype none
`include "assert_macros.svh"
module tcp_probe_header_builder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tphb_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Probe requests
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [15:0]                   destination_port,
	input  wire logic [15:0]                   source_port,
	input  wire logic [31:0]                   sequence_number,
	input  wire logic [15:0]                   ip_ident,
	input  wire logic [2:0]                    probe_kind,
	// Header words
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [31:0]                        header_word,
	output logic [3:0]                         word_index,
	output logic                               last_word
);

	tphb_pkg::cfg_t cfg;

	// Stage 1
	logic        valid_s1;
	logic [15:0] dport_s1, sport_s1, ident_s1;
	logic [31:0] seq_s1;
	logic [5:0]  flags_s1;
	logic [17:0] psum_s1;
	logic [17:0] asum_s1;
	// Stage 2
	logic        valid_s2;
	logic [15:0] dport_s2, sport_s2, ident_s2;
	logic [31:0] seq_s2;
	logic [5:0]  flags_s2;
	logic [19:0] sum_s2;
	// Stage 3: serializer
	logic        valid_s3;
	logic [15:0] dport_s3, sport_s3, ident_s3;
	logic [31:0] seq_s3;
	logic [5:0]  flags_s3;
	logic [15:0] ck_s3;
	logic [3:0]  cnt_s3;

	logic in_fire, out_fire, s3_free, adv3, s2_free, adv2, s1_free;
	logic [16:0] fold1;
	logic [15:0] fold2;

	tphb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline handshake
	assign out_valid = valid_s3;
	assign out_fire = valid_s3 && !out_stall;
	assign s3_free = !valid_s3 || (out_fire && (cnt_s3 == tphb_pkg::LAST_IDX));
	assign adv3 = valid_s2 && s3_free;
	assign s2_free = !valid_s2 || adv3;
	assign adv2 = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || adv2;
	assign in_stall = !s1_free;
	assign in_fire = in_valid && s1_free;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			cnt_s3 <= tphb_pkg::FIRST_IDX;
		end else begin
			if (s1_free) valid_s1 <= in_valid;
			if (s2_free) valid_s2 <= valid_s1;
			if (s3_free) begin
				valid_s3 <= valid_s2;
				cnt_s3 <= tphb_pkg::FIRST_IDX;
			end else if (out_fire) begin
				cnt_s3 <= cnt_s3 + 4'd1;
			end
		end
	end

	// Stage 1: capture request, partial sums of ports/sequence and addresses
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dport_s1 <= destination_port;
			sport_s1 <= source_port;
			seq_s1 <= sequence_number;
			ident_s1 <= ip_ident;
			flags_s1 <= tphb_pkg::kind_flags(probe_kind);
			psum_s1 <= {2'b0, source_port} + {2'b0, destination_port}
				+ {2'b0, sequence_number[31:16]} + {2'b0, sequence_number[15:0]};
			asum_s1 <= {2'b0, cfg.source_address[31:16]} + {2'b0, cfg.source_address[15:0]}
				+ {2'b0, cfg.dest_address[31:16]} + {2'b0, cfg.dest_address[15:0]};
		end
	end

	// Stage 2: complete the ones'-complement sum
	always_ff @(posedge clk) begin
		if (adv2) begin
			dport_s2 <= dport_s1;
			sport_s2 <= sport_s1;
			seq_s2 <= seq_s1;
			ident_s2 <= ident_s1;
			flags_s2 <= flags_s1;
			sum_s2 <= {2'b0, psum_s1} + {2'b0, asum_s1}
				+ {4'b0, tphb_pkg::TCP_OFF_HI | {10'b0, flags_s1}}
				+ {4'b0, tphb_pkg::TCP_WINDOW} + {4'b0, tphb_pkg::PSEUDO_CONST};
		end
	end

	// Fold carries; the complement is taken as stage 3 loads
	assign fold1 = {13'b0, sum_s2[19:16]} + {1'b0, sum_s2[15:0]};
	assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

	// Stage 3: load the serializer
	always_ff @(posedge clk) begin
		if (adv3) begin
			dport_s3 <= dport_s2;
			sport_s3 <= sport_s2;
			seq_s3 <= seq_s2;
			ident_s3 <= ident_s2;
			flags_s3 <= flags_s2;
			ck_s3 <= ~fold2;
		end
	end

	// Select the current header word
	always_comb begin
		case (cnt_s3)
			4'd0: header_word = tphb_pkg::IP_WORD0;
			4'd1: header_word = {ident_s3, tphb_pkg::IP_DF};
			4'd2: header_word = tphb_pkg::IP_WORD2;
			4'd3: header_word = cfg.source_address;
			4'd4: header_word = cfg.dest_address;
			4'd5: header_word = {sport_s3, dport_s3};
			4'd6: header_word = seq_s3;
			4'd7: header_word = 32'h0;
			4'd8: header_word = {tphb_pkg::TCP_OFF_HI | {10'b0, flags_s3}, tphb_pkg::TCP_WINDOW};
			4'd9: header_word = {ck_s3, 16'h0};
			default: header_word = 32'h0;
		endcase
	end

	assign word_index = cnt_s3;
	assign last_word = (cnt_s3 == tphb_pkg::LAST_IDX);

	`ASSERT_NEXT(a_no_drop_mid_header, clk, arst_n, out_fire && !last_word, out_valid && (word_index == $past(word_index) + 4'd1))
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid && out_stall, out_valid && (word_index == $past(word_index)))
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !s3_free, valid_s2 && $stable(sum_s2))
	`ASSERT_SAME(a_cnt_range, clk, arst_n, valid_s3, cnt_s3 <= tphb_pkg::LAST_IDX)

endmodule
`default_nettype wire

/* test/tcp_probe_header_checker.sv */
`timescale 1ns / 100ps
module tcp_probe_header_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tphb_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	input  wire logic [31:0]                 prdata,
	input  wire logic                        pready,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [15:0]                 destination_port,
	input  wire logic [15:0]                 source_port,
	input  wire logic [31:0]                 sequence_number,
	input  wire logic [15:0]                 ip_ident,
	input  wire logic [2:0]                  probe_kind,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [31:0]                 header_word,
	input  wire logic [3:0]                  word_index,
	input  wire logic                        last_word,
	output int unsigned                      fail_count,
	output int unsigned                      words_pending
);

	localparam logic [tphb_pkg::ADDR_W-1:0] SOURCE_ADDR = {tphb_pkg::REG_SOURCE, 2'b00};
	localparam logic [tphb_pkg::ADDR_W-1:0] TARGET_ADDR = {tphb_pkg::REG_TARGET, 2'b00};

	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  index;
		logic        last;
	} header_beat_t;

	header_beat_t expected_beats[$];
	logic [31:0] cur_source;
	logic [31:0] cur_target;

	// Assemble the full IPv4+TCP header, TCP checksum included
	function automatic logic [9:0][31:0] build_header(
		input logic [31:0] src,
		input logic [31:0] tgt,
		input logic [15:0] dport,
		input logic [15:0] sport,
		input logic [31:0] seq,
		input logic [15:0] ident,
		input logic [2:0]  kind
	);
		logic [5:0] flags;
		logic [9:0][31:0] h;
		logic [31:0] sum;
		if (kind[0]) begin
			flags = tphb_pkg::FL_FIN;
		end else if (kind[1]) begin
			flags = tphb_pkg::FL_SYN;
		end else if (kind[2]) begin
			flags = tphb_pkg::FL_FIN | tphb_pkg::FL_PSH | tphb_pkg::FL_URG;
		end else begin
			flags = tphb_pkg::FL_NONE;
		end
		h[0] = tphb_pkg::IP_WORD0;
		h[1] = {ident, tphb_pkg::IP_DF};
		h[2] = tphb_pkg::IP_WORD2;
		h[3] = src;
		h[4] = tgt;
		h[5] = {sport, dport};
		h[6] = seq;
		h[7] = 32'h0;
		h[8] = {tphb_pkg::TCP_OFF_HI | {10'd0, flags}, tphb_pkg::TCP_WINDOW};
		h[9] = 32'h0;
		// Sum addresses (pseudo-header) and TCP words, then fold twice
		sum = {16'h0, tphb_pkg::PSEUDO_CONST};
		for (int i = 3; i < 9; i++) begin
			sum = sum + {16'h0, h[i][31:16]} + {16'h0, h[i][15:0]};
		end
		sum = {16'h0, sum[31:16]} + {16'h0, sum[15:0]};
		sum = sum + {16'h0, sum[31:16]};
		h[9] = {~sum[15:0], 16'h0000};
		return h;
	endfunction

	// Track registers, queue expected words, compare delivered words
	always @(posedge clk or negedge arst_n) begin : monitor
		int unsigned errs;
		header_beat_t got;
		header_beat_t want;
		logic [9:0][31:0] hdr;
		logic [31:0] reg_value;
		if (!arst_n) begin
			cur_source <= 32'h0;
			cur_target <= 32'h0;
			expected_beats.delete();
			fail_count <= 0;
			words_pending <= 0;
		end else begin
			errs = 0;
			// Register transaction: apply writes, check reads
			if (psel && penable && pready) begin
				reg_value = (paddr == SOURCE_ADDR) ? cur_source : cur_target;
				if (pwrite) begin
					if (paddr == SOURCE_ADDR) begin
						cur_source <= pwdata;
					end else if (paddr == TARGET_ADDR) begin
						cur_target <= pwdata;
					end
				end else if (prdata !== reg_value) begin
					$error("prdata: expected %h, got %h", reg_value, prdata);
					errs++;
				end
			end
			// Header word transaction: match against the oldest expectation
			if (out_valid && !out_stall) begin
				got = '{word: header_word, index: word_index, last: last_word};
				if (expected_beats.size() == 0) begin
					$error("header_word %h arrived with nothing expected", header_word);
					errs++;
				end else begin
					want = expected_beats.pop_front();
					if (got.word !== want.word) begin
						$error("header_word: expected %h, got %h", want.word, got.word);
						errs++;
					end
					if (got.index !== want.index) begin
						$error("word_index: expected %0d, got %0d", want.index, got.index);
						errs++;
					end
					if (got.last !== want.last) begin
						$error("last_word: expected %0b, got %0b", want.last, got.last);
						errs++;
					end
				end
			end
			// Probe transaction: queue the ten header words it produces
			if (in_valid && !in_stall) begin
				hdr = build_header(cur_source, cur_target, destination_port, source_port,
					sequence_number, ip_ident, probe_kind);
				for (int i = 0; i < tphb_pkg::HDR_WORDS; i++) begin
					want.word = hdr[i];
					want.index = 4'(i);
					want.last = (4'(i) == tphb_pkg::LAST_IDX);
					expected_beats.push_back(want);
				end
			end
			fail_count <= fail_count + errs;
			words_pending <= expected_beats.size();
		end
	end

endmodule

/* test/tb_tcp_probe_header_builder.sv */
`timescale 1ns / 100ps
module tb_tcp_probe_header_builder;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PROBES_PER_PHASE = 30;
	localparam int unsigned PHASE_COUNT = 5;
	localparam logic [tphb_pkg::ADDR_W-1:0] SOURCE_ADDR = {tphb_pkg::REG_SOURCE, 2'b00};
	localparam logic [tphb_pkg::ADDR_W-1:0] TARGET_ADDR = {tphb_pkg::REG_TARGET, 2'b00};

	typedef struct packed {
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] seq;
		logic [15:0] ident;
		logic [2:0]  kind;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tphb_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [15:0] destination_port;
	logic [15:0] source_port;
	logic [31:0] sequence_number;
	logic [15:0] ip_ident;
	logic [2:0] probe_kind;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] header_word;
	logic [3:0] word_index;
	logic last_word;
	int unsigned fail_count;
	int unsigned words_pending;
	int unsigned idle_pct = 0;
	int unsigned stall_left = 0;

	tcp_probe_header_builder u_dut (.*);

	tcp_probe_header_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the header output in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Abort when no transaction moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				return 32'h0;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic probe_t make_probe(input logic [15:0] dport, input logic [15:0] sport,
		input logic [31:0] seq, input logic [15:0] ident, input logic [2:0] kind);
		probe_t p;
		p.dport = dport;
		p.sport = sport;
		p.seq = seq;
		p.ident = ident;
		p.kind = kind;
		return p;
	endfunction

	function automatic probe_t random_probe();
		return make_probe(16'(pick_value()), 16'(pick_value()), pick_value(),
			16'(pick_value()), 3'($urandom_range(0, 7)));
	endfunction

	// Offer one probe, with an optional gap first; hold until accepted
	task automatic send_probe(input probe_t p);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		destination_port <= p.dport;
		source_port <= p.sport;
		sequence_number <= p.seq;
		ip_ident <= p.ident;
		probe_kind <= p.kind;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and let every queued header drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [tphb_pkg::ADDR_W-1:0] addr,
		input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] src, input logic [31:0] tgt);
		apb_access(1'b1, SOURCE_ADDR, src);
		apb_access(1'b1, TARGET_ADDR, tgt);
		apb_access(1'b0, SOURCE_ADDR, 32'h0);
		apb_access(1'b0, TARGET_ADDR, 32'h0);
	endtask

	initial begin : stimulus
		logic [31:0] src_cfg;
		logic [31:0] tgt_cfg;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'h0;
		in_valid = 1'b0;
		destination_port = 16'h0;
		source_port = 16'h0;
		sequence_number = 32'h0;
		ip_ident = 16'h0;
		probe_kind = 3'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers read back as zero after reset
		apb_access(1'b0, SOURCE_ADDR, 32'h0);
		apb_access(1'b0, TARGET_ADDR, 32'h0);

		// Directed probes with zero addresses
		idle_pct = 25;
		send_probe(make_probe(16'h0, 16'h0, 32'h0, 16'h0, 3'd0));
		send_probe(make_probe(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd7));
		// Port sum that makes the TCP checksum come out as zero
		send_probe(make_probe(16'h3DD5, 16'h0, 32'h0, 16'h0, 3'd0));
		send_probe(make_probe(16'hFFFF, 16'h0, 32'h8000_0000, 16'h0, 3'd4));
		send_probe(make_probe(16'h0, 16'hFFFF, 32'h0000_FFFF, 16'hFFFF, 3'd2));
		for (int k = 0; k < 8; k++) begin
			send_probe(make_probe(16'(pick_value()), 16'(pick_value()), pick_value(),
				16'(pick_value()), 3'(k)));
		end
		wait_idle();

		// Random probes under several address settings; no idling at the end
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					src_cfg = 32'hFFFF_FFFF;
					tgt_cfg = 32'hFFFF_FFFF;
				end
				1: begin
					src_cfg = 32'h0;
					tgt_cfg = 32'hFFFF_FFFF;
				end
				2: begin
					src_cfg = 32'hFFFF_FFFF;
					tgt_cfg = 32'h0;
				end
				default: begin
					src_cfg = $urandom();
					tgt_cfg = $urandom();
				end
			endcase
			configure(src_cfg, tgt_cfg);
			idle_pct = (phase == PHASE_COUNT - 1) ? 0 : (phase == 2) ? 0 : (phase % 2) ? 50 : 20;
			for (int n = 0; n < PROBES_PER_PHASE; n++) begin
				send_probe(random_probe());
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
